// ===== rtl/iirlp_pkg.sv =====
// Shared constants, types and coefficient tables of the eleventh-order low-pass filter.
package iirlp_pkg;

  localparam int FilterOrder = 11;
  localparam int SampleW     = 16;
  localparam int HistW       = 32;
  localparam int CoefW       = 16;
  localparam int AccW        = 52;
  localparam int DenShift    = 10;
  localparam int OutShift    = 14;
  localparam int AddrW       = $clog2(FilterOrder);
  localparam int TapW        = $clog2(FilterOrder + 1);
  localparam int NumProdW    = CoefW + SampleW;
  localparam int DenProdW    = CoefW + HistW;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [HistW-1:0]   hist_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic signed [AccW-1:0]    acc_t;
  typedef logic [AddrW-1:0]          addr_t;
  typedef logic [TapW-1:0]           tap_t;

  typedef struct packed {
    sample_t x;
    hist_t   y;
  } entry_t;

  typedef struct packed {
    logic   en;
    addr_t  addr;
    entry_t data;
  } wr_req_t;

  localparam addr_t LastAddr = addr_t'(FilterOrder - 1);
  localparam tap_t  LastTap  = tap_t'(FilterOrder);

  function automatic coef_t num_coef(tap_t k);
    coef_t c;
    case (k)
      4'd0:    c = 16'sd45;
      4'd1:    c = 16'sd499;
      4'd2:    c = 16'sd2495;
      4'd3:    c = 16'sd7486;
      4'd4:    c = 16'sd14973;
      4'd5:    c = 16'sd20963;
      4'd6:    c = 16'sd20963;
      4'd7:    c = 16'sd14973;
      4'd8:    c = 16'sd7486;
      4'd9:    c = 16'sd2495;
      4'd10:   c = 16'sd499;
      4'd11:   c = 16'sd45;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Tap zero carries no feedback term.
  function automatic coef_t den_coef(tap_t k);
    coef_t c;
    case (k)
      4'd1:    c = -16'sd5268;
      4'd2:    c = 16'sd12979;
      4'd3:    c = -16'sd20044;
      4'd4:    c = 16'sd21426;
      4'd5:    c = -16'sd16567;
      4'd6:    c = 16'sd9421;
      4'd7:    c = -16'sd3928;
      4'd8:    c = 16'sd1173;
      4'd9:    c = -16'sd238;
      4'd10:   c = 16'sd29;
      4'd11:   c = -16'sd1;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/iirlp_if.sv =====
// Valid/ready stream interfaces for input and output samples.
interface iirlp_in_if;
  logic                valid;
  logic                ready;
  iirlp_pkg::sample_t  sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirlp_out_if;
  logic                valid;
  logic                ready;
  iirlp_pkg::sample_t  sample_out;

  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

// ===== rtl/iirlp_hist_mem.sv =====
// History memory: input and output history pairs with per-entry valid bits.
module iirlp_hist_mem (
  input  logic               clk,
  input  logic               rst,
  input  iirlp_pkg::wr_req_t wr,
  input  iirlp_pkg::addr_t   raddr,
  output iirlp_pkg::entry_t  rdata
);
  import iirlp_pkg::*;

  entry_t                 mem [FilterOrder];
  logic [FilterOrder-1:0] vld;
  entry_t                 mem_q;
  logic                   vld_q;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      vld_q <= vld[raddr];
    end
  end

  // unwritten entries read as zero
  assign rdata = vld_q ? mem_q : '0;

endmodule

// ===== rtl/iir_lowpass_order11_direct_form1_top.sv =====
// Top level of the eleventh-order direct form I low-pass filter.
// Each accepted sample runs through the states in turn before the next one is taken: the idle state
// takes the request, then twelve taps stream one per cycle through the single read port of the
// history memory into one shared pair of multipliers, followed by pipeline drain, the divide
// by 1024 with saturation, and then the divide by 16384, history write and result load. A
// finished result waits in the output register while the next sample is taken; the block
// stalls before its own result load if that register is still full.
module iir_lowpass_order11_direct_form1_top (
  input logic clk,
  input logic rst,
  iirlp_in_if.sink    in_ch,
  iirlp_out_if.source out_ch
);
  import iirlp_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StMac   = 3'd1;
  localparam logic [2:0] StDrain = 3'd2;
  localparam logic [2:0] StHist  = 3'd3;
  localparam logic [2:0] StOut   = 3'd4;

  localparam int QuoW = AccW - DenShift;
  localparam int OutQuoW = HistW - OutShift;

  logic [2:0]              state;
  sample_t                 sample;
  tap_t                    tap;
  addr_t                   rd_addr;
  addr_t                   head;
  addr_t                   wr_addr;
  logic                    s1_valid;
  tap_t                    s1_tap;
  logic                    s2_valid;
  logic signed [NumProdW-1:0] px;
  logic signed [DenProdW-1:0] py;
  logic signed [NumProdW-1:0] px_next;
  logic signed [DenProdW-1:0] py_next;
  sample_t                 x_sel;
  acc_t                    acc;
  acc_t                    acc_adj;
  logic signed [QuoW-1:0]  quo;
  hist_t                   hist_next;
  hist_t                   hist;
  hist_t                   hist_adj;
  logic signed [OutQuoW-1:0] out_quo;
  sample_t                 out_next;
  logic                    out_valid;
  sample_t                 out_data;
  logic                    load_out;
  entry_t                  rdata;
  wr_req_t                 wr;

  assign in_ch.ready       = (state == StIdle);
  assign out_ch.valid      = out_valid;
  assign out_ch.sample_out = out_data;

  assign wr_addr  = (head == LastAddr) ? '0 : head + addr_t'(1);
  assign load_out = (state == StOut) && (!out_valid || out_ch.ready);

  assign wr.en     = load_out;
  assign wr.addr   = wr_addr;
  assign wr.data.x = sample;
  assign wr.data.y = hist;

  iirlp_hist_mem u_hist_mem (
    .clk   (clk),
    .rst   (rst),
    .wr    (wr),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  // tap zero takes the new sample instead of a stored one
  assign x_sel   = (s1_tap == '0) ? sample : rdata.x;
  assign px_next = num_coef(s1_tap) * x_sel;
  assign py_next = den_coef(s1_tap) * rdata.y;

  // truncate toward zero: bias negatives before the arithmetic shift
  assign acc_adj = acc + acc_t'({{(AccW-DenShift){1'b0}}, {DenShift{acc[AccW-1]}}});
  assign quo     = acc_adj[AccW-1:DenShift];

  always_comb begin
    if ((&quo[QuoW-1:HistW-1]) || !(|quo[QuoW-1:HistW-1])) begin
      hist_next = quo[HistW-1:0];
    end else if (quo[QuoW-1]) begin
      hist_next = {1'b1, {(HistW-1){1'b0}}};
    end else begin
      hist_next = {1'b0, {(HistW-1){1'b1}}};
    end
  end

  assign hist_adj = hist + hist_t'({{(HistW-OutShift){1'b0}}, {OutShift{hist[HistW-1]}}});
  assign out_quo  = hist_adj[HistW-1:OutShift];

  always_comb begin
    if ((&out_quo[OutQuoW-1:SampleW-1]) || !(|out_quo[OutQuoW-1:SampleW-1])) begin
      out_next = out_quo[SampleW-1:0];
    end else if (out_quo[OutQuoW-1]) begin
      out_next = {1'b1, {(SampleW-1){1'b0}}};
    end else begin
      out_next = {1'b0, {(SampleW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= StIdle;
      head      <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      s1_valid <= (state == StMac);
      s2_valid <= s1_valid;
      if (load_out) begin
        out_valid <= 1'b1;
        head      <= wr_addr;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        StIdle: begin
          if (in_ch.valid) begin
            state <= StMac;
          end
        end
        StMac: begin
          if (tap == LastTap) begin
            state <= StDrain;
          end
        end
        StDrain: begin
          if (!s1_valid && !s2_valid) begin
            state <= StHist;
          end
        end
        StHist: begin
          state <= StOut;
        end
        StOut: begin
          if (load_out) begin
            state <= StIdle;
          end
        end
        default: begin
          state <= StIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_tap <= tap;
    px     <= px_next;
    py     <= py_next;
    if (state == StIdle) begin
      sample  <= in_ch.sample_in;
      acc     <= '0;
      tap     <= '0;
      rd_addr <= head;
    end else if (state == StMac) begin
      tap <= tap + tap_t'(1);
      // newest entry serves tap one, so hold the address over tap zero
      if (tap != '0) begin
        rd_addr <= (rd_addr == '0) ? LastAddr : rd_addr - addr_t'(1);
      end
    end
    if (s2_valid) begin
      acc <= acc + acc_t'(px) - acc_t'(py);
    end
    if (state == StHist) begin
      hist <= hist_next;
    end
    if (load_out) begin
      out_data <= out_next;
    end
  end

  a_accept_empty: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |-> (!s1_valid && !s2_valid))
    else $error("request accepted while the tap pipeline is busy");

  a_hist_drained: assert property (@(posedge clk) disable iff (rst)
    (state == StHist) |-> (!s1_valid && !s2_valid))
    else $error("scaling started before the accumulator settled");

  a_write_then_result: assert property (@(posedge clk) disable iff (rst)
    wr.en |=> out_valid)
    else $error("history written without a result presented");

  a_s2_follows_s1: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> $past(s1_valid))
    else $error("product stage valid without a preceding read");

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the eleventh-order direct form I low-pass filter: streams samples, checks each result.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import iirlp_pkg::*;

  localparam int  HalfPeriod = 5;
  localparam int  ResetCycles = 9;
  localparam int  MaxGap = 16;
  localparam int  HoldCycles = 400;
  localparam int  DrainCycles = 40;
  localparam int  CycleLimit = 200000;
  localparam longint DenScale = 1024;
  localparam longint OutScale = 16384;
  localparam longint HistMax = 64'sd2147483647;
  localparam longint HistMin = -64'sd2147483648;
  localparam longint SampleMax = 32767;
  localparam longint SampleMin = -32768;

  logic clk = 1'b0;
  logic rst = 1'b1;

  iirlp_in_if  in_ch ();
  iirlp_out_if out_ch ();

  iir_lowpass_order11_direct_form1_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic    in_valid = 1'b0;
  sample_t in_sample = '0;
  logic    rx_ready = 1'b0;

  assign in_ch.valid     = in_valid;
  assign in_ch.sample_in = in_sample;
  assign out_ch.ready    = rx_ready;

  int fwd_coef [0:FilterOrder] = '{45, 499, 2495, 7486, 14973, 20963,
                                   20963, 14973, 7486, 2495, 499, 45};
  int fb_coef  [0:FilterOrder] = '{1024, -5268, 12979, -20044, 21426, -16567,
                                   9421, -3928, 1173, -238, 29, -1};

  sample_t x_hist [FilterOrder];
  hist_t   y_hist [FilterOrder];

  sample_t expected_out [$];
  bit      idle_on = 1'b1;
  bit      hold_off = 1'b0;
  int      errors = 0;
  int      samples_sent = 0;
  int      results_seen = 0;
  int      rx_seen_last = 0;
  int      rx_wait = 0;
  int      sat_hits = 0;
  int      cycle_count = 0;

  always begin
    #HalfPeriod clk = 1'b1;
    #HalfPeriod clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic sample_t filter_step(sample_t x);
    longint acc;
    longint y_new;
    longint o_new;
    acc = longint'(fwd_coef[0]) * longint'(x);
    for (int k = 1; k <= FilterOrder; k++) begin
      acc += longint'(fwd_coef[k]) * longint'(x_hist[k-1]);
      acc -= longint'(fb_coef[k]) * longint'(y_hist[k-1]);
    end
    y_new = acc / DenScale;
    if (y_new > HistMax) y_new = HistMax;
    if (y_new < HistMin) y_new = HistMin;
    for (int k = FilterOrder - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k-1];
      y_hist[k] = y_hist[k-1];
    end
    x_hist[0] = x;
    y_hist[0] = hist_t'(y_new);
    o_new = y_new / OutScale;
    if (o_new > SampleMax || o_new < SampleMin) sat_hits++;
    if (o_new > SampleMax) o_new = SampleMax;
    if (o_new < SampleMin) o_new = SampleMin;
    return sample_t'(o_new);
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    if (errors <= 20) begin
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
  endtask

  // hold valid across back-to-back requests; lower it only ahead of a gap
  task automatic send_sample(sample_t s);
    int gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= s;
    do @(posedge clk); while (!in_ch.ready);
    expected_out.push_back(filter_step(s));
    samples_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_out.size() == 0) begin
        report_mismatch("unrequested sample_out", out_ch.sample_out, 0);
      end else begin
        sample_t want;
        want = expected_out.pop_front();
        if (out_ch.sample_out !== want) begin
          report_mismatch("sample_out", out_ch.sample_out, want);
        end
      end
      results_seen++;
    end
  end

  always @(negedge clk) begin
    if (results_seen != rx_seen_last) begin
      rx_seen_last = results_seen;
      rx_wait = idle_on ? $urandom_range(0, MaxGap) : 0;
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
    rx_ready <= (rx_wait == 0) && !hold_off;
  end

  task automatic test_directed_extremes();
    sample_t pattern [$];
    pattern = {16'sh7fff, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000,
               16'sh0001, 16'shffff};
    foreach (pattern[i]) send_sample(pattern[i]);
    repeat (8) send_sample(16'sh7fff);
    repeat (8) send_sample(16'sh8000);
  endtask

  task automatic test_random_noise();
    repeat (250) send_sample(sample_t'($urandom()));
  endtask

  // drive the filter hard: held levels with small dither, so it settles and saturates
  task automatic test_shaped_signals();
    int level;
    int len;
    int v;
    int count;
    count = 0;
    while (count < 300) begin
      case ($urandom_range(0, 3))
        0:       level = 32767;
        1:       level = -32768;
        default: level = int'(sample_t'($urandom()));
      endcase
      len = $urandom_range(8, 40);
      repeat (len) begin
        v = level + $urandom_range(0, 255) - 128;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        send_sample(sample_t'(v));
        count++;
      end
    end
  endtask

  task automatic test_output_backpressure();
    idle_on = 1'b0;
    fork
      begin
        hold_off = 1'b1;
        repeat (HoldCycles) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    repeat (40) send_sample(sample_t'($urandom()));
    idle_on = 1'b1;
  endtask

  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (90) send_sample(sample_t'($urandom()));
    idle_on = 1'b1;
  endtask

  initial begin
    foreach (x_hist[i]) x_hist[i] = '0;
    foreach (y_hist[i]) y_hist[i] = '0;
    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed_extremes();
    test_random_noise();
    test_shaped_signals();
    test_output_backpressure();
    test_back_to_back();

    in_valid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Streamed %0d samples and checked %0d results, %0d of them saturated.",
             samples_sent, results_seen, sat_hits);
    $display("Covered full-scale steps, noise, held levels and a %0d-cycle output stall.",
             HoldCycles);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
